### hw/rtl/sib_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sib_pkg
// Shared types and constants of the snapshot interpolation buffer.
// ----------------------------------------------------------------------------
package sib_pkg;

   localparam int DEPTH  = 16;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [1:0] FUNC_PUSH   = 2'd0;
   localparam logic [1:0] FUNC_SAMPLE = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [2:0] ST_PUSHED   = 3'd0;
   localparam logic [2:0] ST_REJECTED = 3'd1;
   localparam logic [2:0] ST_VALID    = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;

   localparam logic CSR_MAX_EXTRAP = 1'b0;
   localparam logic CSR_SEC_TICK   = 1'b1;

   localparam logic [23:0] MAX_EXTRAP_RESET = 24'd512;
   localparam logic [23:0] SEC_TICK_RESET   = 24'd279620;

   typedef struct packed {
      logic [31:0]      stamp;
      logic [5:0][31:0] vec;
      logic [15:0]      heading;
      logic [7:0]       act;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_CHECK, S_DIV, S_DTMUL, S_DTLATCH, S_MUL, S_ACC, S_RESP
   } state_type;

endpackage

### hw/rtl/sib_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sib_req_if
// Request channel of the snapshot interpolation buffer.
// ----------------------------------------------------------------------------
interface sib_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [31:0]        stamp;
   logic [39:0]        query_time;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic signed [15:0] heading;
   logic [7:0]         act_code;

   modport source (output valid, func, stamp, query_time, pos_x, pos_y, pos_z,
                   vel_x, vel_y, vel_z, heading, act_code, input ready);
   modport sink (input valid, func, stamp, query_time, pos_x, pos_y, pos_z,
                 vel_x, vel_y, vel_z, heading, act_code, output ready);
endinterface

### hw/rtl/sib_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sib_rsp_if
// Response channel of the snapshot interpolation buffer.
// ----------------------------------------------------------------------------
interface sib_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [31:0] out_pos_x;
   logic signed [31:0] out_pos_y;
   logic signed [31:0] out_pos_z;
   logic signed [31:0] out_vel_x;
   logic signed [31:0] out_vel_y;
   logic signed [31:0] out_vel_z;
   logic signed [15:0] out_heading;
   logic [7:0]         out_act;

   modport source (output valid, status, out_pos_x, out_pos_y, out_pos_z,
                   out_vel_x, out_vel_y, out_vel_z, out_heading, out_act,
                   input ready);
   modport sink (input valid, status, out_pos_x, out_pos_y, out_pos_z,
                 out_vel_x, out_vel_y, out_vel_z, out_heading, out_act,
                 output ready);
endinterface

### hw/rtl/sib_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sib_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sib_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### hw/rtl/snapshot_interpolation_buffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snapshot_interpolation_buffer_unit
// Ring of timestamped transforms with interpolating and extrapolating sample.
// ----------------------------------------------------------------------------
// The block takes one request at a time on req_chan and answers each with one
// response on rsp_chan. A push, a clear, an unused code or a sample on an
// empty ring is answered in the cycle after it is taken. A sample walks the
// stored entries oldest first through the entry RAM, with a read state and a
// check state per entry. A hit on the oldest entry answers at once; a hit
// further on runs a 17-step restoring divider for the blend weight and then
// seven multiply and accumulate steps, each a multiply state and an accumulate
// state, on one shared 34 by 34 multiplier. A sample past the newest entry
// takes one multiply for the time step and three for the positions.
// The response register holds its response until rsp_chan.ready is seen; a new
// request is taken only after that. Reset empties the ring and reloads the
// two configuration registers; the entry RAM itself is not cleared, since
// only written entries are ever read.
// ----------------------------------------------------------------------------
module snapshot_interpolation_buffer_unit (
   input  logic        clock,
   input  logic        reset,
   sib_req_if.sink     req_chan,
   sib_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);
   import sib_pkg::*;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, idx_ff;
   logic [SLOT_W-1:0]      oldest_ff;
   logic [31:0]            newest_ff;
   logic [23:0]            max_extrap_ff, sec_tick_ff;
   logic [39:0]            query_ff;
   entry_type              prev_ff, cur_ff, ram_rdata, ram_wdata;
   logic                   ram_we;
   logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
   logic [47:0]            rem_ff, dsh_ff;
   logic [16:0]            alpha_ff;
   logic [4:0]             bit_ff;
   logic [2:0]             lane_ff;
   logic                   extrap_ff;
   logic [23:0]            ticks_ff;
   logic [31:0]            dt_ff;
   logic signed [67:0]     prod_ff;
   logic signed [33:0]     mul_a, mul_b;
   logic [2:0]             status_ff;
   entry_type              out_ff;
   logic                   req_take, hit, div_ge;
   logic [39:0]            qdiff;
   logic [15:0]            hd_diff;

   function automatic logic [SLOT_W-1:0] slot_of(logic [SLOT_W-1:0] base,
                                                 logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - SLOT_W){1'b0}}, base} + {1'b0, off};
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

   sib_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_chan.func == FUNC_SAMPLE && count_ff != '0) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (hit) begin
               state_in = (idx_ff == '0) ? S_RESP : S_DIV;
            end else if (idx_ff + 1'b1 == count_ff) begin
               state_in = S_DTMUL;
            end else begin
               state_in = S_READ;
            end
         end
         S_DIV: state_in = (bit_ff == '0) ? S_MUL : S_DIV;
         S_DTMUL: state_in = S_DTLATCH;
         S_DTLATCH: state_in = S_MUL;
         S_MUL: state_in = S_ACC;
         S_ACC: begin
            if (lane_ff == (extrap_ff ? 3'd2 : 3'd6)) begin
               state_in = S_RESP;
            end else begin
               state_in = S_MUL;
            end
         end
         S_RESP: state_in = rsp_chan.ready ? S_IDLE : S_RESP;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == S_IDLE);
      rsp_chan.valid = (state_ff == S_RESP);
      ram_raddr      = slot_of(oldest_ff, idx_ff);
      ram_we         = 1'b0;
      ram_waddr      = (count_ff < CNT_W'(DEPTH)) ? slot_of(oldest_ff, count_ff) : oldest_ff;
      ram_wdata.stamp   = req_chan.stamp;
      ram_wdata.vec     = {req_chan.vel_z, req_chan.vel_y, req_chan.vel_x,
                           req_chan.pos_z, req_chan.pos_y, req_chan.pos_x};
      ram_wdata.heading = req_chan.heading;
      ram_wdata.act     = req_chan.act_code;
      if (state_ff == S_IDLE && req_chan.valid && req_chan.func == FUNC_PUSH &&
          !(count_ff != '0 && req_chan.stamp <= newest_ff)) begin
         ram_we = 1'b1;
      end
   end

   assign req_take = req_chan.valid && req_chan.ready;
   assign hit      = query_ff <= {ram_rdata.stamp, 8'h00};
   assign qdiff    = query_ff - {ram_rdata.stamp, 8'h00};
   assign div_ge   = rem_ff >= dsh_ff;
   assign hd_diff  = cur_ff.heading - prev_ff.heading;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_DTMUL) begin
         mul_a = {10'b0, ticks_ff};
         mul_b = {10'b0, sec_tick_ff};
      end else if (extrap_ff) begin
         mul_a = 34'(signed'(prev_ff.vec[lane_ff + 3'd3]));
         mul_b = {2'b0, dt_ff};
      end else if (lane_ff == 3'd6) begin
         mul_a = {{18{hd_diff[15]}}, hd_diff};
         mul_b = {17'b0, alpha_ff};
      end else begin
         mul_a = 34'(signed'({cur_ff.vec[lane_ff][31], cur_ff.vec[lane_ff]})
                     - signed'({prev_ff.vec[lane_ff][31], prev_ff.vec[lane_ff]}));
         mul_b = {17'b0, alpha_ff};
      end
   end

   always_ff @(posedge clock) begin
      logic signed [67:0] sh;
      logic signed [67:0] tr;
      logic signed [51:0] sum;
      sh  = prod_ff >>> 16;
      tr  = (prod_ff < 0) ? ((prod_ff + 68'sd65535) >>> 16) : sh;
      sum = 52'(signed'(out_ff.vec[lane_ff])) + sh[51:0];
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         oldest_ff     <= '0;
         max_extrap_ff <= MAX_EXTRAP_RESET;
         sec_tick_ff   <= SEC_TICK_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_EXTRAP: max_extrap_ff <= csr_wdata;
               default:        sec_tick_ff   <= csr_wdata;
            endcase
         end
         if (req_take && req_chan.func == FUNC_CLEAR) begin
            count_ff  <= '0;
            oldest_ff <= '0;
         end
         if (ram_we) begin
            newest_ff <= req_chan.stamp;
            if (count_ff < CNT_W'(DEPTH)) begin
               count_ff <= count_ff + 1'b1;
            end else begin
               oldest_ff <= slot_of(oldest_ff, CNT_W'(1));
            end
         end
      end

      case (state_ff)
         S_IDLE: begin
            query_ff  <= req_chan.query_time;
            idx_ff    <= '0;
            lane_ff   <= '0;
            extrap_ff <= 1'b0;
            out_ff    <= '0;
            if (req_chan.func == FUNC_PUSH) begin
               status_ff <= ram_we ? ST_PUSHED : ST_REJECTED;
            end else if (req_chan.func == FUNC_SAMPLE) begin
               status_ff <= (count_ff != '0) ? ST_VALID : ST_EMPTY;
            end else if (req_chan.func == FUNC_CLEAR) begin
               status_ff <= ST_CLEARED;
            end else begin
               status_ff <= ST_EMPTY;
            end
         end
         S_CHECK: begin
            cur_ff <= ram_rdata;
            if (hit) begin
               out_ff    <= ram_rdata;
               rem_ff    <= {query_ff - {prev_ff.stamp, 8'h00}, 8'h00};
               dsh_ff    <= {ram_rdata.stamp - prev_ff.stamp, 16'h0000};
               bit_ff    <= 5'd16;
               alpha_ff  <= '0;
               extrap_ff <= 1'b0;
            end else begin
               prev_ff   <= ram_rdata;
               out_ff    <= ram_rdata;
               idx_ff    <= idx_ff + 1'b1;
               extrap_ff <= 1'b1;
               ticks_ff  <= (qdiff > {16'b0, max_extrap_ff}) ? max_extrap_ff : qdiff[23:0];
            end
         end
         S_DIV: begin
            if (div_ge) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            dsh_ff   <= dsh_ff >> 1;
            alpha_ff <= {alpha_ff[15:0], div_ge};
            bit_ff   <= bit_ff - 1'b1;
            if (bit_ff == '0) begin
               out_ff.act <= ({alpha_ff[15:0], div_ge} < 17'd32768) ? prev_ff.act
                                                                   : cur_ff.act;
            end
         end
         S_DTMUL: prod_ff <= mul_a * mul_b;
         S_DTLATCH: dt_ff <= prod_ff[47:16];
         S_MUL: begin
            prod_ff <= mul_a * mul_b;
            if (!extrap_ff && lane_ff == '0) begin
               out_ff.vec     <= prev_ff.vec;
               out_ff.heading <= prev_ff.heading;
            end
         end
         S_ACC: begin
            lane_ff <= lane_ff + 1'b1;
            if (extrap_ff) begin
               if (sum > 52'sd2147483647) begin
                  out_ff.vec[lane_ff] <= 32'h7fffffff;
               end else if (sum < -52'sd2147483648) begin
                  out_ff.vec[lane_ff] <= 32'h80000000;
               end else begin
                  out_ff.vec[lane_ff] <= sum[31:0];
               end
            end else if (lane_ff == 3'd6) begin
               out_ff.heading <= prev_ff.heading + tr[15:0];
            end else begin
               out_ff.vec[lane_ff] <= prev_ff.vec[lane_ff] + sh[31:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_chan.status      = status_ff;
   assign rsp_chan.out_pos_x   = out_ff.vec[0];
   assign rsp_chan.out_pos_y   = out_ff.vec[1];
   assign rsp_chan.out_pos_z   = out_ff.vec[2];
   assign rsp_chan.out_vel_x   = out_ff.vec[3];
   assign rsp_chan.out_vel_y   = out_ff.vec[4];
   assign rsp_chan.out_vel_z   = out_ff.vec[5];
   assign rsp_chan.out_heading = out_ff.heading;
   assign rsp_chan.out_act     = out_ff.act;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a response is pending");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != ST_VALID |->
      rsp_chan.out_pos_x == 0 && rsp_chan.out_act == 0)
      else $error("payload not zero on a non-sample response");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_take && req_chan.func == FUNC_CLEAR |=> count_ff == '0)
      else $error("clear left entries behind");
endmodule
